// ===== hw/rtl/pid_difference_equation_assert.svh =====
// Assertion macros shared by the RTL of the PID difference-equation block.
// Define NO_ASSERTIONS to compile them away; the user module must have clk and rst_n.
`ifndef PID_DIFFERENCE_EQUATION_ASSERT_SVH
`define PID_DIFFERENCE_EQUATION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset
`define PDEQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pdeq assertion failed");

// Trigger in one cycle implies consequence in the next
`define PDEQ_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("pdeq assertion failed");

// Trigger implies consequence in the same cycle
`define PDEQ_ASSERT_IMPL(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("pdeq assertion failed");

`else

`define PDEQ_ASSERT_ALWAYS(label, cond)
`define PDEQ_ASSERT_NEXT(label, trig, cons)
`define PDEQ_ASSERT_IMPL(label, trig, cons)

`endif

`endif

// ===== hw/rtl/pdeq_pkg.sv =====
// Shared types and constants of the PID difference-equation block.
// No dependencies; used by pdeq_core and pid_difference_equation.
`default_nettype none

package pdeq_pkg;

    // Coefficient format: signed Q12.20, 32 bits
    localparam int COEF_W    = 32;
    localparam int NUM_COEFS = 5;

    // Register map: index = byte address / 4
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    // Reset values of the coefficients
    localparam logic signed [COEF_W-1:0] B0_RESET = 32'sd4738334;
    localparam logic signed [COEF_W-1:0] B1_RESET = -32'sd9320028;
    localparam logic signed [COEF_W-1:0] B2_RESET = 32'sd4582987;
    localparam logic signed [COEF_W-1:0] A1_RESET = 32'sd2071261;
    localparam logic signed [COEF_W-1:0] A2_RESET = -32'sd1022685;

    // Full coefficient set handed to the datapath
    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_set_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pdeq_core.sv =====
// Difference-equation datapath: error/output history and the combinational
// multiply-accumulate with shift and saturation. Depends on pdeq_pkg.
`default_nettype none

module pdeq_core #(
    parameter int FRAC_BITS    = 20,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   accept,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   error_sample,
    input  wire pdeq_pkg::coef_set_t              coefs,
    output logic signed [SAMPLE_WIDTH-1:0]        control_value,
    output logic                                  saturated
);

    localparam int PROD_W = pdeq_pkg::COEF_W + SAMPLE_WIDTH;
    localparam int ACC_W  = PROD_W + 3;
    localparam int TOP_LO = FRAC_BITS + SAMPLE_WIDTH - 1;

    localparam logic signed [SAMPLE_WIDTH-1:0] VAL_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] VAL_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] error_prev1_reg;
    logic signed [SAMPLE_WIDTH-1:0] error_prev2_reg;
    logic signed [SAMPLE_WIDTH-1:0] output_prev1_reg;
    logic signed [SAMPLE_WIDTH-1:0] output_prev2_reg;

    logic signed [PROD_W-1:0] prod_b0;
    logic signed [PROD_W-1:0] prod_b1;
    logic signed [PROD_W-1:0] prod_b2;
    logic signed [PROD_W-1:0] prod_a1;
    logic signed [PROD_W-1:0] prod_a2;
    logic signed [ACC_W-1:0]  acc;
    logic [ACC_W-1-TOP_LO:0]  acc_top;
    logic                     in_range;

    // Five independent products
    assign prod_b0 = coefs.b0 * error_sample;
    assign prod_b1 = coefs.b1 * error_prev1_reg;
    assign prod_b2 = coefs.b2 * error_prev2_reg;
    assign prod_a1 = coefs.a1 * output_prev1_reg;
    assign prod_a2 = coefs.a2 * output_prev2_reg;

    // Exact sum, wide enough never to wrap
    assign acc = ACC_W'(prod_a1) + ACC_W'(prod_a2) + ACC_W'(prod_b0)
               + ACC_W'(prod_b1) + ACC_W'(prod_b2);

    // Floor shift by FRAC_BITS, then clip to the sample range
    assign acc_top  = acc[ACC_W-1:TOP_LO];
    assign in_range = (&acc_top) || (~|acc_top);

    always_comb
    begin
        saturated = !in_range;
        if (in_range)
            control_value = acc[TOP_LO:FRAC_BITS];
        else if (acc[ACC_W-1])
            control_value = VAL_MIN;
        else
            control_value = VAL_MAX;
    end

    // Advance the history on each accepted beat; the clipped value feeds back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_prev1_reg  <= '0;
            error_prev2_reg  <= '0;
            output_prev1_reg <= '0;
            output_prev2_reg <= '0;
        end
        else if (accept)
        begin
            error_prev1_reg  <= error_sample;
            error_prev2_reg  <= error_prev1_reg;
            output_prev1_reg <= control_value;
            output_prev2_reg <= output_prev1_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pid_difference_equation.sv =====
// Channel   | Dir | Beat contents (low bit up)              | Handshake
// s_axis    | in  | tdata: error_sample                     | tvalid/tready
// m_axis    | out | tdata: control_value; tuser: saturated  | tvalid/tready
// apb       | in  | coef_b0..coef_a2 at 0x00..0x10          | psel/penable, pready=1
//
// One error beat per cycle while the output is not stalled; the result appears in the cycle after acceptance.
// The loop through output_prev1 (five products, adder, clip) sets the clock.
// A one-deep output register holds the result; input is taken while that
// register is empty or being drained. Reset clears history and coefficients
// to their defaults; write coefficients only while the block is idle.
// Top level of the PID difference-equation block; uses pdeq_pkg, pdeq_core
// and the assertion macros in pid_difference_equation_assert.svh.
`default_nettype none
`include "pid_difference_equation_assert.svh"

module pid_difference_equation #(
    parameter int FRAC_BITS    = 20,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // error sample stream
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // error_sample
    // control output stream
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata,  // control_value
    output logic [0:0]                         m_axis_tuser,  // saturated
    // configuration
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [pdeq_pkg::PADDR_W-1:0]        paddr,
    input  wire [pdeq_pkg::COEF_W-1:0]         pwdata,
    output logic [pdeq_pkg::COEF_W-1:0]        prdata,
    output logic                               pready
);

    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    localparam logic signed [SAMPLE_WIDTH-1:0] VAL_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] VAL_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    pdeq_pkg::coef_set_t coef_reg;
    pdeq_pkg::coef_set_t coef_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_value_reg;
    logic                           out_sat_reg;

    logic [pdeq_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;
    logic                           in_accept;
    logic signed [SAMPLE_WIDTH-1:0] error_sample;
    logic signed [SAMPLE_WIDTH-1:0] core_value;
    logic                           core_sat;

    // Configuration port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[pdeq_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                pdeq_pkg::REG_B0: coef_next.b0 = pwdata;
                pdeq_pkg::REG_B1: coef_next.b1 = pwdata;
                pdeq_pkg::REG_B2: coef_next.b2 = pwdata;
                pdeq_pkg::REG_A1: coef_next.a1 = pwdata;
                pdeq_pkg::REG_A2: coef_next.a2 = pwdata;
                default:          coef_next    = coef_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pdeq_pkg::REG_B0: prdata = coef_reg.b0;
            pdeq_pkg::REG_B1: prdata = coef_reg.b1;
            pdeq_pkg::REG_B2: prdata = coef_reg.b2;
            pdeq_pkg::REG_A1: prdata = coef_reg.a1;
            pdeq_pkg::REG_A2: prdata = coef_reg.a2;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= pdeq_pkg::B0_RESET;
            coef_reg.b1 <= pdeq_pkg::B1_RESET;
            coef_reg.b2 <= pdeq_pkg::B2_RESET;
            coef_reg.a1 <= pdeq_pkg::A1_RESET;
            coef_reg.a2 <= pdeq_pkg::A2_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // Input handshake: take a beat while the output register is free or draining
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign error_sample  = s_axis_tdata[SAMPLE_WIDTH-1:0];

    pdeq_core #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .error_sample  (error_sample),
        .coefs         (coef_reg),
        .control_value (core_value),
        .saturated     (core_sat)
    );

    // Output register: load on accept, hold while stalled
    assign out_valid_next = in_accept || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_value_reg <= core_value;
            out_sat_reg   <= core_sat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'($unsigned(out_value_reg));
    assign m_axis_tuser  = out_sat_reg;

    // Checks
    `PDEQ_ASSERT_IMPL(a_sat_at_limit, out_valid_reg && out_sat_reg,
        out_value_reg == VAL_MAX || out_value_reg == VAL_MIN)
    `PDEQ_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_reg)
    `PDEQ_ASSERT_IMPL(a_stall_only_when_full, !s_axis_tready,
        out_valid_reg && !m_axis_tready)

endmodule

`default_nettype wire
